/* rtl/tcr_pkg.sv */
// Shared types and constants for the triangle coverage rasterizer.
// Used by tcr_ctrl, tcr_dp and triangle_coverage_rasterizer_unit; no dependencies.
package tcr_pkg;

  localparam int TCR_COORD_W = 18;   // vertex coordinate width
  localparam int TCR_FRAC_W  = 16;   // fraction bits
  localparam int TCR_CFG_W   = 9;    // map_width / map_height register width
  localparam int TCR_ADDR_W  = 3;    // APB byte address width
  localparam int TCR_DATA_W  = 32;   // APB data width
  localparam int TCR_WORD_W  = 32;   // coverage bits per memory word
  localparam int TCR_WORD_LG = 5;    // log2 of TCR_WORD_W
  localparam int TCR_STEP_W  = 4;

  localparam logic [TCR_FRAC_W-1:0] TCR_HALF_PX = 16'h8000;

  // register select (byte address bit 2)
  localparam logic TCR_REG_WIDTH  = 1'b0;
  localparam logic TCR_REG_HEIGHT = 1'b1;

  // sequencing steps of the shared multiplier
  localparam logic [TCR_STEP_W-1:0] TCR_NUM_COORD    = 4'd6;
  localparam logic [TCR_STEP_W-1:0] TCR_STEP_ROWBASE = 4'd6;
  localparam logic [TCR_STEP_W-1:0] TCR_WB_LAG       = 4'd2;
  localparam logic [TCR_STEP_W-1:0] TCR_SCALE_LAST   = 4'd7;
  localparam logic [TCR_STEP_W-1:0] TCR_SETUP_LAST   = 4'd8;

  typedef struct packed {
    logic                  load;   // capture input transfer
    logic                  clr;    // clear one memory word
    logic                  scale;  // vertex scaling step
    logic                  box;    // bounding box and edge deltas
    logic                  setup;  // edge and row base setup step
    logic                  rd;     // read coverage word of current pixel
    logic                  wr;     // mark current pixel
    logic                  adv;    // move to next pixel
    logic [TCR_STEP_W-1:0] step;
  } tcr_cmd_t;

  typedef struct packed {
    logic box_empty;
    logic covered;
    logic last_px;
    logic hit;
    logic clr_last;
  } tcr_stat_t;

endpackage

/* rtl/tcr_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tcr_ctrl.sv */
// Controller state machine of the triangle coverage rasterizer.
// Depends on tcr_pkg; drives tcr_dp through tcr_cmd_t, reads tcr_stat_t.
module tcr_ctrl
  import tcr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      mode_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic      overlap_o,
  output tcr_cmd_t  cmd_o,
  input  tcr_stat_t stat_i
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CLEAR = 9'b000000100,
    S_SCALE = 9'b000001000,
    S_BOX   = 9'b000010000,
    S_SETUP = 9'b000100000,
    S_WALK  = 9'b001000000,
    S_CHECK = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e                state_q, state_d;
  logic [TCR_STEP_W-1:0] cnt_q, cnt_d;
  logic                  ovl_q, ovl_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_ovl_q, out_ovl_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovl_d       = ovl_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_ovl_d   = out_ovl_q;
    cmd_o       = '0;
    cmd_o.step  = cnt_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          ovl_d      = 1'b0;
          cnt_d      = '0;
          state_d    = mode_i ? S_CLEAR : S_SCALE;
        end
      end
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_DONE;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == TCR_SCALE_LAST) begin
          cnt_d   = '0;
          state_d = S_BOX;
        end
      end
      S_BOX: begin
        cmd_o.box = 1'b1;
        state_d   = stat_i.box_empty ? S_DONE : S_SETUP;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == TCR_SETUP_LAST) begin
          cnt_d   = '0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.covered) begin
          cmd_o.rd = 1'b1;
          state_d  = S_CHECK;
        end else begin
          cmd_o.adv = 1'b1;
          if (stat_i.last_px) begin
            state_d = S_DONE;
          end
        end
      end
      S_CHECK: begin
        if (stat_i.hit) begin
          ovl_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.wr  = 1'b1;
          cmd_o.adv = 1'b1;
          state_d   = stat_i.last_px ? S_DONE : S_WALK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_ovl_d   = ovl_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      ovl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovl_q       <= ovl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ovl_q <= out_ovl_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign overlap_o   = out_ovl_q;

  a_hit_stops_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && stat_i.hit) |=> (state_q == S_DONE && ovl_q))
    else $error("walk did not stop on an already marked pixel");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside of the done state");

  a_clear_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && mode_i) |=> (state_q == S_CLEAR))
    else $error("clear transfer did not start the clear sweep");

endmodule

/* rtl/tcr_dp.sv */
// Datapath of the triangle coverage rasterizer: vertex scaling, bounding box,
// incremental edge functions, pixel walk and the coverage memory.
// Depends on tcr_pkg and tcr_ram.
module tcr_dp
  import tcr_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcr_cmd_t                      cmd_i,
  output tcr_stat_t                     stat_o,
  input  logic [TCR_CFG_W-1:0]          map_width_i,
  input  logic [TCR_CFG_W-1:0]          map_height_i,
  input  logic signed [TCR_COORD_W-1:0] ax_i,
  input  logic signed [TCR_COORD_W-1:0] ay_i,
  input  logic signed [TCR_COORD_W-1:0] bx_i,
  input  logic signed [TCR_COORD_W-1:0] by_coord_i,
  input  logic signed [TCR_COORD_W-1:0] cx_i,
  input  logic signed [TCR_COORD_W-1:0] cy_i
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int SZW   = (WW > HW) ? WW : HW;
  localparam int EXW   = (SZW > TCR_CFG_W) ? SZW : TCR_CFG_W;
  localparam int CW    = TCR_COORD_W + SZW;
  localparam int MW    = CW + 1;
  localparam int PW    = 2 * MW;
  localparam int EW    = PW + 1;
  localparam int FW    = CW - TCR_FRAC_W;
  localparam int NPIX  = MAX_WIDTH * MAX_HEIGHT;
  localparam int IW    = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int DEPTH = (NPIX + TCR_WORD_W - 1) / TCR_WORD_W;
  localparam int DAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // effective map size
  logic [SZW-1:0] w_eff, h_eff;
  always_comb begin
    w_eff = (EXW'(map_width_i) > EXW'(MAX_WIDTH)) ? SZW'(MAX_WIDTH) : SZW'(map_width_i);
    h_eff = (EXW'(map_height_i) > EXW'(MAX_HEIGHT)) ? SZW'(MAX_HEIGHT)
                                                    : SZW'(map_height_i);
  end

  // vertex, box and walk registers
  logic signed [CW-1:0] x_q [3];
  logic signed [CW-1:0] y_q [3];
  logic signed [MW-1:0] da_q [3];
  logic signed [MW-1:0] db_q [3];
  logic signed [EW-1:0] erow_q [3];
  logic signed [EW-1:0] ecur_q [3];
  logic [SZW-1:0]       lox_q, hix_q, loy_q, hiy_q, px_q, py_q;
  logic [IW-1:0]        rowb_q;
  logic signed [MW-1:0] opa_q, opb_q, opa_d, opb_d;
  logic signed [PW-1:0] prod_q;
  logic [DAW-1:0]       clra_q;

  // bounding box
  logic signed [FW-1:0] fx [3];
  logic signed [FW-1:0] fy [3];
  logic signed [FW-1:0] minx, maxx, miny, maxy, wm1, hm1;
  logic signed [FW-1:0] lox_s, hix_s, loy_s, hiy_s;
  logic                 box_empty;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fx[k] = x_q[k][CW-1:TCR_FRAC_W];
      fy[k] = y_q[k][CW-1:TCR_FRAC_W];
    end
    minx = fx[0];
    maxx = fx[0];
    miny = fy[0];
    maxy = fy[0];
    for (int k = 1; k < 3; k++) begin
      if (fx[k] < minx) minx = fx[k];
      if (fx[k] > maxx) maxx = fx[k];
      if (fy[k] < miny) miny = fy[k];
      if (fy[k] > maxy) maxy = fy[k];
    end
    wm1   = $signed(FW'(w_eff) - FW'(1));
    hm1   = $signed(FW'(h_eff) - FW'(1));
    lox_s = minx[FW-1] ? '0 : minx;
    loy_s = miny[FW-1] ? '0 : miny;
    hix_s = (maxx > wm1) ? wm1 : maxx;
    hiy_s = (maxy > hm1) ? hm1 : maxy;
    box_empty = (lox_s > hix_s) || (loy_s > hiy_s);
  end

  // shared multiplier operand selection
  logic [1:0]            ck, wk;
  logic [TCR_STEP_W-1:0] wj;
  logic signed [MW-1:0]  base_sel;
  logic signed [CW-1:0]  crd_sel;

  always_comb begin
    ck       = cmd_i.step[2:1];
    wj       = cmd_i.step - TCR_WB_LAG;
    wk       = wj[2:1];
    opa_d    = opa_q;
    opb_d    = opb_q;
    base_sel = cmd_i.step[0] ? $signed(MW'({loy_q, TCR_HALF_PX}))
                             : $signed(MW'({lox_q, TCR_HALF_PX}));
    crd_sel  = cmd_i.step[0] ? y_q[ck] : x_q[ck];
    if (cmd_i.scale && (cmd_i.step < TCR_NUM_COORD)) begin
      opa_d = MW'(crd_sel);
      opb_d = $signed(MW'(cmd_i.step[0] ? h_eff : w_eff));
    end else if (cmd_i.setup && (cmd_i.step == TCR_STEP_ROWBASE)) begin
      opa_d = $signed(MW'(loy_q));
      opb_d = $signed(MW'(w_eff));
    end else if (cmd_i.setup && (cmd_i.step < TCR_STEP_ROWBASE)) begin
      opa_d = cmd_i.step[0] ? db_q[ck] : da_q[ck];
      opb_d = base_sel - MW'(crd_sel);
    end
  end

  logic last_col;
  assign last_col = (px_q == hix_q);

  always_ff @(posedge clk_i) begin
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    prod_q <= opa_q * opb_q;
    if (cmd_i.load) begin
      x_q[0] <= CW'(ax_i);
      y_q[0] <= CW'(ay_i);
      x_q[1] <= CW'(bx_i);
      y_q[1] <= CW'(by_coord_i);
      x_q[2] <= CW'(cx_i);
      y_q[2] <= CW'(cy_i);
    end
    if (cmd_i.scale && (cmd_i.step >= TCR_WB_LAG)) begin
      if (wj[0]) begin
        y_q[wk] <= $signed(prod_q[CW-1:0]);
      end else begin
        x_q[wk] <= $signed(prod_q[CW-1:0]);
      end
    end
    if (cmd_i.box) begin
      lox_q <= SZW'(lox_s);
      hix_q <= SZW'(hix_s);
      loy_q <= SZW'(loy_s);
      hiy_q <= SZW'(hiy_s);
      px_q  <= SZW'(lox_s);
      py_q  <= SZW'(loy_s);
      for (int k = 0; k < 3; k++) begin
        da_q[k] <= MW'(y_q[(k == 2) ? 0 : k + 1]) - MW'(y_q[k]);
        db_q[k] <= MW'(x_q[(k == 2) ? 0 : k + 1]) - MW'(x_q[k]);
      end
    end
    if (cmd_i.setup && (cmd_i.step >= TCR_WB_LAG)) begin
      if (wj == TCR_STEP_ROWBASE) begin
        rowb_q <= prod_q[IW-1:0];
      end else if (wj[0]) begin
        erow_q[wk] <= erow_q[wk] - EW'(prod_q);
        ecur_q[wk] <= erow_q[wk] - EW'(prod_q);
      end else begin
        erow_q[wk] <= EW'(prod_q);
        ecur_q[wk] <= EW'(prod_q);
      end
    end
    if (cmd_i.adv) begin
      if (last_col) begin
        px_q   <= lox_q;
        py_q   <= py_q + 1'b1;
        rowb_q <= rowb_q + IW'(w_eff);
        for (int k = 0; k < 3; k++) begin
          erow_q[k] <= erow_q[k] - (EW'(db_q[k]) << TCR_FRAC_W);
          ecur_q[k] <= erow_q[k] - (EW'(db_q[k]) << TCR_FRAC_W);
        end
      end else begin
        px_q <= px_q + 1'b1;
        for (int k = 0; k < 3; k++) begin
          ecur_q[k] <= ecur_q[k] + (EW'(da_q[k]) << TCR_FRAC_W);
        end
      end
    end
  end

  // clear sweep address
  logic clr_last;
  assign clr_last = (clra_q == DAW'(DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clra_q <= '0;
    end else if (cmd_i.clr) begin
      clra_q <= clr_last ? '0 : clra_q + 1'b1;
    end
  end

  // coverage test and memory access
  logic [2:0]                  pos, neg;
  logic [IW-1:0]               idx;
  logic [IW+TCR_WORD_LG-1:0]   idx_ext;
  logic [DAW-1:0]              word_addr;
  logic [TCR_WORD_LG-1:0]      bit_sel;
  logic [TCR_WORD_W-1:0]       rdata, set_word;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg[k] = ecur_q[k][EW-1];
      pos[k] = !ecur_q[k][EW-1] && (ecur_q[k] != '0);
    end
    idx       = rowb_q + IW'(px_q);
    idx_ext   = {{TCR_WORD_LG{1'b0}}, idx};
    bit_sel   = idx_ext[TCR_WORD_LG-1:0];
    word_addr = DAW'(idx_ext >> TCR_WORD_LG);
    set_word  = rdata | (TCR_WORD_W'(1) << bit_sel);
  end

  tcr_ram #(
    .WIDTH (TCR_WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr | cmd_i.wr),
    .waddr_i (cmd_i.clr ? clra_q : word_addr),
    .wdata_i (cmd_i.clr ? '0 : set_word),
    .re_i    (cmd_i.rd),
    .raddr_i (word_addr),
    .rdata_o (rdata)
  );

  assign stat_o.box_empty = box_empty;
  assign stat_o.covered   = (&pos) | (&neg);
  assign stat_o.last_px   = last_col && (py_q == hiy_q);
  assign stat_o.hit       = rdata[bit_sel];
  assign stat_o.clr_last  = clr_last;

  a_mark_fresh : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |-> (!rdata[bit_sel] && !cmd_i.clr))
    else $error("marking a pixel that is already marked or during clear");

endmodule

/* rtl/triangle_coverage_rasterizer_unit.sv */
// Steps: a clear sweeps every map word to zero; a triangle is scaled, its box clipped
// and its edges set up, then the box is walked, each covered pixel read and then marked;
// an empty box skips setup and walk. One transfer at a time: in_stall_o is high until done.
// Reset: map_width/map_height return to 256 and the map is swept to zero, one 32-bit
// word per cycle with in_stall_o high; APB writes still land.
// Top level of the triangle coverage rasterizer; depends on tcr_pkg, tcr_ctrl, tcr_dp.
module triangle_coverage_rasterizer_unit
  import tcr_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [TCR_ADDR_W-1:0]         paddr,
  input  logic [TCR_DATA_W-1:0]         pwdata,
  output logic [TCR_DATA_W-1:0]         prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic signed [TCR_COORD_W-1:0] ax_i,
  input  logic signed [TCR_COORD_W-1:0] ay_i,
  input  logic signed [TCR_COORD_W-1:0] bx_i,
  input  logic signed [TCR_COORD_W-1:0] by_coord_i,
  input  logic signed [TCR_COORD_W-1:0] cx_i,
  input  logic signed [TCR_COORD_W-1:0] cy_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          overlap_o
);

  logic [TCR_CFG_W-1:0] map_width_q, map_height_q;
  logic                 reg_sel, cfg_wr;
  tcr_cmd_t             cmd;
  tcr_stat_t            stat;

  assign reg_sel = paddr[TCR_ADDR_W-1];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= 9'd256;
      map_height_q <= 9'd256;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        TCR_REG_WIDTH:  map_width_q  <= pwdata[TCR_CFG_W-1:0];
        TCR_REG_HEIGHT: map_height_q <= pwdata[TCR_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      TCR_REG_WIDTH:  prdata = TCR_DATA_W'(map_width_q);
      TCR_REG_HEIGHT: prdata = TCR_DATA_W'(map_height_q);
      default:        prdata = '0;
    endcase
  end

  tcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .overlap_o   (overlap_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  tcr_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .ax_i         (ax_i),
    .ay_i         (ay_i),
    .bx_i         (bx_i),
    .by_coord_i   (by_coord_i),
    .cx_i         (cx_i),
    .cy_i         (cy_i)
  );

endmodule

/* verif/tcr_tb_pkg.sv */
// Overlap scoreboard for the triangle coverage rasterizer bench: keeps a private coverage
// map and size registers and predicts the overlap bit of every input transfer.
// Depends on tcr_pkg.
`timescale 1ns / 100ps
package tcr_tb_pkg;
  import tcr_pkg::*;

  localparam int     TB_MAX_W  = 256;
  localparam int     TB_MAX_H  = 256;
  localparam int     MAP_CELLS = TB_MAX_W * TB_MAX_H;
  localparam longint PIXEL     = longint'(1) << TCR_FRAC_W;

  localparam logic MODE_RASTER = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic                             mode;
    logic [2:0][TCR_COORD_W-1:0]      u;
    logic [2:0][TCR_COORD_W-1:0]      v;
  } tri_item_t;

  class overlap_scoreboard;
    bit                   cov_map [MAP_CELLS];
    logic [TCR_CFG_W-1:0] width_reg;
    logic [TCR_CFG_W-1:0] height_reg;
    bit                   expected_overlap [$];
    int                   errors;
    int                   results;
    int                   overlaps;

    function new();
      width_reg  = TCR_CFG_W'(TB_MAX_W);
      height_reg = TCR_CFG_W'(TB_MAX_H);
      errors     = 0;
      results    = 0;
      overlaps   = 0;
      foreach (cov_map[i]) cov_map[i] = 1'b0;
    endfunction

    function void write_reg(bit is_height, logic [TCR_CFG_W-1:0] val);
      if (is_height) height_reg = val;
      else width_reg = val;
    endfunction

    function longint edge_val(longint x0, longint y0, longint x1, longint y1,
                              longint px, longint py);
      return (y1 - y0) * (px - x0) - (x1 - x0) * (py - y0);
    endfunction

    // Walks the clipped box and marks covered pixels; stops at the first one already set.
    function void rasterize(tri_item_t item);
      longint w, h, lox, hix, loy, hiy, x, y, fx, fy, ctr_x, ctr_y, e0, e1, e2, idx;
      longint vx [3];
      longint vy [3];
      bit     hit;
      hit = 1'b0;
      if (item.mode == MODE_CLEAR) begin
        foreach (cov_map[i]) cov_map[i] = 1'b0;
        expected_overlap.push_back(1'b0);
        return;
      end
      w = (width_reg > TB_MAX_W) ? TB_MAX_W : width_reg;
      h = (height_reg > TB_MAX_H) ? TB_MAX_H : height_reg;
      if (w == 0 || h == 0) begin
        expected_overlap.push_back(1'b0);
        return;
      end
      for (int i = 0; i < 3; i++) begin
        vx[i] = longint'($signed(item.u[i])) * w;
        vy[i] = longint'($signed(item.v[i])) * h;
      end
      lox = vx[0] >>> TCR_FRAC_W;
      hix = lox;
      loy = vy[0] >>> TCR_FRAC_W;
      hiy = loy;
      for (int i = 1; i < 3; i++) begin
        fx = vx[i] >>> TCR_FRAC_W;
        fy = vy[i] >>> TCR_FRAC_W;
        if (fx < lox) lox = fx;
        if (fx > hix) hix = fx;
        if (fy < loy) loy = fy;
        if (fy > hiy) hiy = fy;
      end
      if (lox < 0) lox = 0;
      if (loy < 0) loy = 0;
      if (hix > w - 1) hix = w - 1;
      if (hiy > h - 1) hiy = h - 1;
      for (y = loy; y <= hiy && !hit; y++) begin
        ctr_y = y * PIXEL + longint'(TCR_HALF_PX);
        for (x = lox; x <= hix && !hit; x++) begin
          ctr_x = x * PIXEL + longint'(TCR_HALF_PX);
          e0 = edge_val(vx[0], vy[0], vx[1], vy[1], ctr_x, ctr_y);
          e1 = edge_val(vx[1], vy[1], vx[2], vy[2], ctr_x, ctr_y);
          e2 = edge_val(vx[2], vy[2], vx[0], vy[0], ctr_x, ctr_y);
          if ((e0 > 0 && e1 > 0 && e2 > 0) || (e0 < 0 && e1 < 0 && e2 < 0)) begin
            idx = y * w + x;
            if (cov_map[idx]) hit = 1'b1;
            else cov_map[idx] = 1'b1;
          end
        end
      end
      expected_overlap.push_back(hit);
    endfunction

    function void check_overlap(logic actual);
      bit exp_bit;
      results++;
      if (actual === 1'b1) overlaps++;
      if (expected_overlap.size() == 0) begin
        $error("overlap: result transfer with nothing expected, actual %0d", actual);
        errors++;
        return;
      end
      exp_bit = expected_overlap.pop_front();
      if (actual !== exp_bit) begin
        $error("overlap mismatch: expected %0d actual %0d", exp_bit, actual);
        errors++;
      end
    endfunction
  endclass

endpackage

/* verif/testbench.sv */
// Top-level bench for triangle_coverage_rasterizer_unit: directed and random triangles and
// clears under several map sizes, random idle/stall, scoreboard check of every overlap bit.
// Depends on tcr_pkg, tcr_tb_pkg and the rasterizer RTL.
`timescale 1ns / 100ps
module testbench;
  import tcr_pkg::*;
  import tcr_tb_pkg::*;

  localparam int STUCK_LIMIT = 400000;
  localparam logic [TCR_ADDR_W-1:0] ADDR_WIDTH  = {TCR_REG_WIDTH, 2'b00};
  localparam logic [TCR_ADDR_W-1:0] ADDR_HEIGHT = {TCR_REG_HEIGHT, 2'b00};
  localparam longint COORD_MAX = (longint'(1) << (TCR_COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (TCR_COORD_W - 1));

  localparam int SEND_IDLE  [4] = '{0, 52, 0, 24};
  localparam int RECV_STALL [4] = '{0, 0, 52, 24};

  localparam int NUM_PHASES = 11;
  localparam int PHASE_W [NUM_PHASES] = '{1, 256, 1, 8, 16, 37, 0, 300, 511, 64, 256};
  localparam int PHASE_H [NUM_PHASES] = '{1, 1, 256, 4, 16, 23, 12, 0, 511, 200, 256};
  localparam int PHASE_N [NUM_PHASES] = '{30, 30, 30, 40, 60, 60, 10, 10, 60, 60, 100};

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [TCR_ADDR_W-1:0]         paddr       = '0;
  logic [TCR_DATA_W-1:0]         pwdata      = '0;
  logic [TCR_DATA_W-1:0]         prdata;
  logic                          pready;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic                          mode_i      = 1'b0;
  logic signed [TCR_COORD_W-1:0] ax_i        = '0;
  logic signed [TCR_COORD_W-1:0] ay_i        = '0;
  logic signed [TCR_COORD_W-1:0] bx_i        = '0;
  logic signed [TCR_COORD_W-1:0] by_coord_i  = '0;
  logic signed [TCR_COORD_W-1:0] cx_i        = '0;
  logic signed [TCR_COORD_W-1:0] cy_i        = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          overlap_o;

  overlap_scoreboard sb;
  int        sender_pct  = 0;
  int        recv_pct    = 0;
  int        idle_sel    = 0;
  int        items_sent  = 0;
  int        clears_sent = 0;
  int        size_writes = 0;
  int        stuck_cycles = 0;
  bit        have_last   = 1'b0;
  tri_item_t last_tri;

  triangle_coverage_rasterizer_unit #(
    .MAX_WIDTH (TB_MAX_W),
    .MAX_HEIGHT(TB_MAX_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .ax_i       (ax_i),
    .ay_i       (ay_i),
    .bx_i       (bx_i),
    .by_coord_i (by_coord_i),
    .cx_i       (cx_i),
    .cy_i       (cy_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .overlap_o  (overlap_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      sb.check_overlap(overlap_o);
    end
  end

  // no transfer on either side for too long means the block hung
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [TCR_COORD_W-1:0] fit_coord(longint val);
    if (val > COORD_MAX) return TCR_COORD_W'(COORD_MAX);
    if (val < COORD_MIN) return TCR_COORD_W'(COORD_MIN);
    return TCR_COORD_W'(val);
  endfunction

  function automatic tri_item_t make_triangle(int ua, int va, int ub, int vb, int uc, int vc);
    tri_item_t item;
    item.mode = MODE_RASTER;
    item.u[0] = TCR_COORD_W'(ua);
    item.v[0] = TCR_COORD_W'(va);
    item.u[1] = TCR_COORD_W'(ub);
    item.v[1] = TCR_COORD_W'(vb);
    item.u[2] = TCR_COORD_W'(uc);
    item.v[2] = TCR_COORD_W'(vc);
    return item;
  endfunction

  function automatic tri_item_t make_clear(int fill);
    tri_item_t item;
    item = make_triangle(fill, fill, fill, fill, fill, fill);
    item.mode = MODE_CLEAR;
    return item;
  endfunction

  // w and h are the effective sizes, at least 1
  function automatic tri_item_t gen_item(int w, int h);
    tri_item_t item;
    int        pick, span, ctr_x, ctr_y;
    longint    jx, jy;
    pick = $urandom_range(99);
    item.mode = MODE_RASTER;
    for (int i = 0; i < 3; i++) begin
      item.u[i] = TCR_COORD_W'($urandom());
      item.v[i] = TCR_COORD_W'($urandom());
    end
    if (pick < 8) begin
      item.mode = MODE_CLEAR;
    end else if (pick < 23 && w * h <= 4096) begin
      // raw coordinates: anything goes, the walk is cheap on a small map
    end else if (pick < 38 && have_last) begin
      // reversed winding plus jitter over the last triangle: mostly overlaps
      item = last_tri;
      item.u[1] = last_tri.u[2];
      item.v[1] = last_tri.v[2];
      item.u[2] = last_tri.u[1];
      item.v[2] = last_tri.v[1];
      jx = longint'($urandom_range(0, 4 * PIXEL / w)) - 2 * PIXEL / w;
      jy = longint'($urandom_range(0, 4 * PIXEL / h)) - 2 * PIXEL / h;
      for (int i = 0; i < 3; i++) begin
        item.u[i] = fit_coord(longint'($signed(item.u[i])) + jx);
        item.v[i] = fit_coord(longint'($signed(item.v[i])) + jy);
      end
    end else begin
      span  = $urandom_range(1, 12);
      ctr_x = $urandom_range(0, w + 6) - 3;
      ctr_y = $urandom_range(0, h + 6) - 3;
      for (int i = 0; i < 3; i++) begin
        item.u[i] = fit_coord((longint'(ctr_x) * PIXEL + longint'($urandom_range(0, 2 * span * PIXEL))
                               - longint'(span) * PIXEL) / w);
        item.v[i] = fit_coord((longint'(ctr_y) * PIXEL + longint'($urandom_range(0, 2 * span * PIXEL))
                               - longint'(span) * PIXEL) / h);
      end
      last_tri  = item;
      have_last = 1'b1;
    end
    return item;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer, valid left high
  task automatic send_item(tri_item_t item);
    while ($urandom_range(99) < sender_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= item.mode;
    ax_i       <= item.u[0];
    ay_i       <= item.v[0];
    bx_i       <= item.u[1];
    by_coord_i <= item.v[1];
    cx_i       <= item.u[2];
    cy_i       <= item.v[2];
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.rasterize(item);
    items_sent++;
    if (item.mode == MODE_CLEAR) clears_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_overlap.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [TCR_ADDR_W-1:0] addr, logic [TCR_CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= TCR_DATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (wr) begin
      sb.write_reg(addr == ADDR_HEIGHT, val);
    end else if (prdata !== TCR_DATA_W'(val)) begin
      $error("%s readback mismatch: expected %0d actual %0d",
             (addr == ADDR_HEIGHT) ? "map_height" : "map_width", val, prdata);
      sb.errors++;
    end
    @(negedge clk_i);
  endtask

  task automatic set_map_size(int w, int h);
    drain();
    apb_access(1'b1, ADDR_WIDTH, TCR_CFG_W'(w));
    apb_access(1'b1, ADDR_HEIGHT, TCR_CFG_W'(h));
    apb_access(1'b0, ADDR_WIDTH, TCR_CFG_W'(w));
    apb_access(1'b0, ADDR_HEIGHT, TCR_CFG_W'(h));
    psel    <= 1'b0;
    penable <= 1'b0;
    size_writes++;
  endtask

  task automatic run_random(int count);
    int w, h;
    w = (sb.width_reg > TB_MAX_W) ? TB_MAX_W : int'(sb.width_reg);
    h = (sb.height_reg > TB_MAX_H) ? TB_MAX_H : int'(sb.height_reg);
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    have_last = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (k % 20 == 0) begin
        idle_sel   = (idle_sel + 1) % 4;
        sender_pct = SEND_IDLE[idle_sel];
        recv_pct   = RECV_STALL[idle_sel];
      end
      send_item(gen_item(w, h));
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset size 256 x 256: one pixel is 256 coordinate units
    send_item(make_triangle(2560, 2560, 5120, 2560, 2560, 5120));
    send_item(make_triangle(2560, 2560, 2560, 5120, 5120, 2560));   // same, other winding
    send_item(make_triangle(5120, 2560, 5120, 5120, 2560, 5120));   // shares the diagonal edge
    send_item(make_triangle(7680, 7680, 7680, 7680, 7680, 7680));   // degenerate
    send_item(make_triangle(0, 0, 10000, 10000, 20000, 20000));     // collinear
    send_item(make_triangle(-30000, -20000, -10000, -25000, -20000, -5000));
    send_item(make_triangle(70000, 80000, 90000, 70000, 100000, 100000));
    send_item(make_clear(-1));
    send_item(make_triangle(2560, 2560, 5120, 2560, 2560, 5120));
    send_item(make_triangle(-5000, -5000, 6000, -3000, -2000, 7000));
    send_item(make_triangle(60000, 60000, 70000, 62000, 62000, 70000));

    // coordinate extremes on a tiny map
    set_map_size(8, 4);
    send_item(make_triangle(-131072, -131072, 131071, -131072, -131072, 131071));
    send_item(make_triangle(131071, 131071, -131072, 131071, 131071, -131072));
    send_item(make_triangle(-131072, 0, 131071, 0, 0, 131071));
    send_item(make_clear(131071));

    // one triangle over half the full-size map, its bounding box spanning the whole map
    set_map_size(256, 256);
    send_item(make_triangle(0, 0, 65535, 0, 0, 65535));
    send_item(make_clear(-131072));

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_map_size(PHASE_W[p], PHASE_H[p]);
      run_random(PHASE_N[p]);
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("Ran %0d transfers (%0d map clears) over %0d size settings and four idle mixes.",
             items_sent, clears_sent, size_writes);
    $display("Checked %0d results, %0d of them with overlap set.", sb.results, sb.overlaps);
    if (sb.errors == 0 && sb.expected_overlap.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tcr_pkg.sv
rtl/tcr_ram.sv
rtl/tcr_ctrl.sv
rtl/tcr_dp.sv
rtl/triangle_coverage_rasterizer_unit.sv
verif/tcr_tb_pkg.sv
verif/testbench.sv
